>>> rtl/serial_command_frame_parser_core_macros.svh
// ============================================================================
// serial_command_frame_parser_core_macros.svh
// assertion helpers used by the frame parser core rtl
// ============================================================================
`ifndef SERIAL_COMMAND_FRAME_PARSER_CORE_MACROS_SVH
`define SERIAL_COMMAND_FRAME_PARSER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SCFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/scfp_pkg.sv
// ============================================================================
// scfp_pkg
// types, character codes and command decode for the serial frame parser
// ============================================================================
package scfp_pkg;

    localparam int FRAME_MAX_DEFAULT = 32;

    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_Y     = 8'h79;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_D     = 8'h64;

    localparam logic [4:0] CODE_X  = 5'd0;
    localparam logic [4:0] CODE_E  = 5'd1;
    localparam logic [4:0] CODE_Y  = 5'd2;
    localparam logic [4:0] CODE_G  = 5'd3;
    localparam logic [4:0] CODE_R  = 5'd4;
    localparam logic [4:0] CODE_S  = 5'd5;
    localparam logic [4:0] CODE_D1 = 5'd6;
    localparam logic [4:0] CODE_GT = 5'd15;
    localparam logic [4:0] CODE_LT = 5'd16;
    localparam logic [4:0] CODE_A  = 5'd17;
    localparam logic [4:0] CODE_NONE = 5'd0;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CMD,
        PH_COMMA,
        PH_NUM_START,
        PH_NUM_SIGN,
        PH_NUM_DIG,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [4:0]         command_code;
        logic               command_known;
        logic signed [31:0] distance_value;
        logic               distance_updated;
        logic signed [31:0] direction_value;
        logic               direction_updated;
    } t_result;

    typedef struct packed {
        logic       known;
        logic [4:0] code;
    } t_cmd_info;

    function automatic t_cmd_info decode_cmd(input logic [7:0] c);
        t_cmd_info info;
        info.known = 1'b1;
        info.code  = CODE_NONE;
        case (c)
            CH_X:  info.code = CODE_X;
            CH_E:  info.code = CODE_E;
            CH_Y:  info.code = CODE_Y;
            CH_G:  info.code = CODE_G;
            CH_R:  info.code = CODE_R;
            CH_S:  info.code = CODE_S;
            CH_GT: info.code = CODE_GT;
            CH_LT: info.code = CODE_LT;
            default: begin
                if (c inside {[CH_1:CH_9]}) begin
                    info.code = 5'(c - CH_1) + CODE_D1;
                end else if (c inside {[CH_A:CH_D]}) begin
                    info.code = 5'(c - CH_A) + CODE_A;
                end else begin
                    info.known = 1'b0;
                end
            end
        endcase
        return info;
    endfunction

endpackage

>>> rtl/scfp_parser.sv
// ============================================================================
// scfp_parser
// per-byte frame state, number accumulation and distance/direction registers
// ============================================================================
module scfp_parser #(
    parameter int FRAME_MAX = scfp_pkg::FRAME_MAX_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_res_valid,
    output scfp_pkg::t_result    o_res
);

    localparam int CW = $clog2(FRAME_MAX + 1);

    scfp_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]    r_count, n_count;
    logic [7:0]       r_cmd, n_cmd;
    logic             r_neg, n_neg;
    logic [31:0]      r_acc, n_acc;
    logic [1:0]       r_pend, n_pend;
    logic [31:0]      r_staged, n_staged;
    logic [31:0]      r_dist, n_dist;
    logic [31:0]      r_dir, n_dir;

    logic [CW-1:0]    count_inc;
    logic             is_digit;
    logic             is_space;
    logic [35:0]      acc_x10;
    logic [31:0]      acc_digit;
    logic [31:0]      num_val;
    logic             fin_to_dir;
    logic [1:0]       end_pend;
    logic [31:0]      end_acc;
    logic [31:0]      end_staged;
    logic [7:0]       end_cmd;
    scfp_pkg::t_cmd_info cmd_info;

    assign count_inc = r_count + CW'(1);
    assign is_digit  = i_rx_byte inside {[scfp_pkg::CH_0:scfp_pkg::CH_9]};
    assign is_space  = (i_rx_byte == scfp_pkg::CH_SPACE)
                    || (i_rx_byte inside {[scfp_pkg::CH_TAB:scfp_pkg::CH_CR]});

    // acc * 10 + digit as shift-add, clamp at the negative magnitude limit
    assign acc_x10   = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                     + {32'b0, 4'(i_rx_byte - scfp_pkg::CH_0)};
    assign acc_digit = (acc_x10 > {4'b0, scfp_pkg::MAG_LIMIT}) ? scfp_pkg::MAG_LIMIT
                                                                : acc_x10[31:0];

    assign num_val    = r_neg ? (32'd0 - r_acc)
                              : ((r_acc > scfp_pkg::POS_MAX) ? scfp_pkg::POS_MAX : r_acc);
    assign fin_to_dir = (r_cmd == scfp_pkg::CH_E) && !r_pend[1];

    // frame end: close a number still in its digits, then pick the outputs
    always_comb begin
        end_pend   = r_pend;
        end_acc    = r_acc;
        end_staged = r_staged;
        if (r_phase == scfp_pkg::PH_NUM_DIG) begin
            if (fin_to_dir) begin
                end_staged = num_val;
                end_pend   = r_pend | 2'b10;
            end else begin
                end_acc  = num_val;
                end_pend = r_pend | 2'b01;
            end
        end
    end

    assign end_cmd  = (r_phase == scfp_pkg::PH_CMD) ? scfp_pkg::CH_P : r_cmd;
    assign cmd_info = scfp_pkg::decode_cmd(end_cmd);

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_staged    = r_staged;
        n_dist      = r_dist;
        n_dir       = r_dir;
        o_res_valid = 1'b0;

        o_res.command_code      = cmd_info.known ? cmd_info.code : scfp_pkg::CODE_NONE;
        o_res.command_known     = cmd_info.known;
        o_res.distance_value    = end_pend[0] ? end_acc : r_dist;
        o_res.distance_updated  = end_pend[0];
        o_res.direction_value   = end_pend[1] ? end_staged : r_dir;
        o_res.direction_updated = end_pend[1];

        if (i_accept) begin
            if (r_phase == scfp_pkg::PH_IDLE) begin
                if (i_rx_byte == scfp_pkg::CH_Z) begin
                    n_count  = CW'(1);
                    n_cmd    = '0;
                    n_neg    = 1'b0;
                    n_acc    = '0;
                    n_pend   = '0;
                    n_staged = '0;
                    n_phase  = scfp_pkg::PH_CMD;
                end
            end else if (i_rx_byte != scfp_pkg::CH_P) begin
                if (count_inc >= CW'(FRAME_MAX)) begin
                    // overlong frame is dropped
                    n_count  = '0;
                    n_cmd    = '0;
                    n_neg    = 1'b0;
                    n_acc    = '0;
                    n_pend   = '0;
                    n_staged = '0;
                    n_phase  = scfp_pkg::PH_IDLE;
                end else begin
                    n_count = count_inc;
                    case (r_phase)
                        scfp_pkg::PH_CMD: begin
                            n_cmd = i_rx_byte;
                            if (i_rx_byte == scfp_pkg::CH_X || i_rx_byte == scfp_pkg::CH_Y) begin
                                n_phase = scfp_pkg::PH_COMMA;
                            end else if (i_rx_byte == scfp_pkg::CH_E) begin
                                n_neg   = 1'b0;
                                n_acc   = '0;
                                n_phase = scfp_pkg::PH_NUM_START;
                            end else begin
                                n_phase = scfp_pkg::PH_SKIP;
                            end
                        end
                        scfp_pkg::PH_COMMA: begin
                            if (i_rx_byte == scfp_pkg::CH_COMMA) begin
                                n_neg   = 1'b0;
                                n_acc   = '0;
                                n_phase = scfp_pkg::PH_NUM_START;
                            end else begin
                                n_phase = scfp_pkg::PH_SKIP;
                            end
                        end
                        scfp_pkg::PH_NUM_START: begin
                            if (is_space) begin
                                n_phase = scfp_pkg::PH_NUM_START;
                            end else if (i_rx_byte == scfp_pkg::CH_PLUS
                                      || i_rx_byte == scfp_pkg::CH_MINUS) begin
                                n_neg   = (i_rx_byte == scfp_pkg::CH_MINUS);
                                n_phase = scfp_pkg::PH_NUM_SIGN;
                            end else if (is_digit) begin
                                n_acc   = acc_digit;
                                n_phase = scfp_pkg::PH_NUM_DIG;
                            end else begin
                                n_phase = scfp_pkg::PH_SKIP;
                            end
                        end
                        scfp_pkg::PH_NUM_SIGN: begin
                            if (is_digit) begin
                                n_acc   = acc_digit;
                                n_phase = scfp_pkg::PH_NUM_DIG;
                            end else begin
                                n_phase = scfp_pkg::PH_SKIP;
                            end
                        end
                        scfp_pkg::PH_NUM_DIG: begin
                            if (is_digit) begin
                                n_acc = acc_digit;
                            end else if (fin_to_dir) begin
                                n_staged = num_val;
                                n_pend   = r_pend | 2'b10;
                                if (i_rx_byte == scfp_pkg::CH_COMMA) begin
                                    n_neg   = 1'b0;
                                    n_acc   = '0;
                                    n_phase = scfp_pkg::PH_NUM_START;
                                end else begin
                                    n_phase = scfp_pkg::PH_SKIP;
                                end
                            end else begin
                                n_acc   = num_val;
                                n_pend  = r_pend | 2'b01;
                                n_phase = scfp_pkg::PH_SKIP;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end else begin
                // closing byte: emit the result and return to idle
                o_res_valid = 1'b1;
                if (end_pend[0]) begin
                    n_dist = end_acc;
                end
                if (end_pend[1]) begin
                    n_dir = end_staged;
                end
                n_count  = '0;
                n_cmd    = '0;
                n_neg    = 1'b0;
                n_acc    = '0;
                n_pend   = '0;
                n_staged = '0;
                n_phase  = scfp_pkg::PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= scfp_pkg::PH_IDLE;
            r_count  <= '0;
            r_cmd    <= '0;
            r_neg    <= 1'b0;
            r_acc    <= '0;
            r_pend   <= '0;
            r_staged <= '0;
            r_dist   <= '0;
            r_dir    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_cmd    <= n_cmd;
            r_neg    <= n_neg;
            r_acc    <= n_acc;
            r_pend   <= n_pend;
            r_staged <= n_staged;
            r_dist   <= n_dist;
            r_dir    <= n_dir;
        end
    end

endmodule

>>> rtl/serial_command_frame_parser_core.sv
// ============================================================================
// serial_command_frame_parser_core
// parses 'z'<cmd><args>'p' command frames from a received byte stream
// ============================================================================
// usage
//   input channel: one received byte per request on i_rx_byte, taken at a
//   clock edge with i_valid high and o_stall low
//   output channel: one request per completed frame (closing 'p'), carrying
//   the command code, a known flag and the distance/direction registers
//   with their update flags; taken at an edge with o_valid high and i_stall low
//   output timing: the result for a closing byte is registered into the output
//   register, or into the skid when that is held; other bytes produce no output request
//   throughput: one byte per cycle while o_stall is low; a two-entry output
//   buffer (output register plus skid) keeps input flowing while one result
//   waits
//   stall: o_stall rises only when both output entries are full
//   reset: synchronous, active low; parser returns to idle, distance and
//   direction clear to zero, output buffer empties
// ============================================================================
`include "serial_command_frame_parser_core_macros.svh"

module serial_command_frame_parser_core #(
    parameter int FRAME_MAX = scfp_pkg::FRAME_MAX_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    // frame result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [4:0]         o_command_code,
    output logic               o_command_known,
    output logic signed [31:0] o_distance_value,
    output logic               o_distance_updated,
    output logic signed [31:0] o_direction_value,
    output logic               o_direction_updated
);

    logic              in_accept;
    logic              res_valid;
    scfp_pkg::t_result res;

    // output register and skid entry
    logic              r_out_valid, n_out_valid;
    scfp_pkg::t_result r_out, n_out;
    logic              r_skid_valid, n_skid_valid;
    scfp_pkg::t_result r_skid, n_skid;
    logic              out_free;

    // input is held off only while the skid entry is occupied
    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid && !o_stall;

    scfp_parser #(
        .FRAME_MAX (FRAME_MAX)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                // skid drains first; no new result can arrive while it is full
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = res_valid;
                n_out       = res;
            end
        end else if (res_valid) begin
            // output held by the receiver, park the new result
            n_skid_valid = 1'b1;
            n_skid       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid             = r_out_valid;
    assign o_command_code      = r_out.command_code;
    assign o_command_known     = r_out.command_known;
    assign o_distance_value    = r_out.distance_value;
    assign o_distance_updated  = r_out.distance_updated;
    assign o_direction_value   = r_out.direction_value;
    assign o_direction_updated = r_out.direction_updated;

    // skid never fills ahead of the output register
    `SCFP_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid valid with empty output")
    // a full skid blocks input, so the parser cannot produce a result
    `SCFP_ASSERT_NOW(a_no_res_when_full, i_clk, i_rst_n, r_skid_valid, !res_valid, "result lost while skid full")
    // a result arriving behind a stalled output lands in the skid
    `SCFP_ASSERT_NEXT(a_res_parked, i_clk, i_rst_n, res_valid && r_out_valid && i_stall, r_skid_valid, "stalled result not parked")
    // unknown commands report code zero
    `SCFP_ASSERT_NOW(a_unknown_code, i_clk, i_rst_n, r_out_valid && !r_out.command_known, r_out.command_code == scfp_pkg::CODE_NONE, "unknown command with nonzero code")

endmodule

>>> sim/frame_result_checker.sv
// ============================================================================
// frame_result_checker
// tracks accepted bytes, predicts each frame result and compares it with the
// result requests the parser hands out
// ============================================================================
module frame_result_checker #(
    parameter int FRAME_MAX = scfp_pkg::FRAME_MAX_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [4:0]         i_command_code,
    input  logic               i_command_known,
    input  logic signed [31:0] i_distance_value,
    input  logic               i_distance_updated,
    input  logic signed [31:0] i_direction_value,
    input  logic               i_direction_updated,
    output int                 o_fail_count,
    output int                 o_pending
);

    // predictor state
    scfp_pkg::t_phase phase;
    int unsigned      frame_len;
    logic [7:0]       cmd_byte;
    logic             neg;
    logic [31:0]      magnitude;
    logic [31:0]      dist_q;
    logic [31:0]      dir_q;
    logic [31:0]      dir_staged;
    logic [1:0]       staged;

    scfp_pkg::t_result pending_frames[$];
    scfp_pkg::t_result next_frame;
    bit                frame_done;
    int                fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic bit is_blank(input logic [7:0] c);
        return c == scfp_pkg::CH_SPACE || (c >= scfp_pkg::CH_TAB && c <= scfp_pkg::CH_CR);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= scfp_pkg::CH_0 && c <= scfp_pkg::CH_9;
    endfunction

    function automatic void clear_frame();
        frame_len  = 0;
        cmd_byte   = '0;
        phase      = scfp_pkg::PH_IDLE;
        neg        = 1'b0;
        magnitude  = '0;
        staged     = '0;
        dir_staged = '0;
    endfunction

    function automatic void begin_number();
        neg       = 1'b0;
        magnitude = '0;
        phase     = scfp_pkg::PH_NUM_START;
    endfunction

    function automatic void shift_in_digit(input logic [7:0] c);
        longint unsigned wide;
        wide = 64'(magnitude) * 10 + 64'(c - scfp_pkg::CH_0);
        magnitude = (wide > 64'(scfp_pkg::MAG_LIMIT)) ? scfp_pkg::MAG_LIMIT : wide[31:0];
        phase = scfp_pkg::PH_NUM_DIG;
    endfunction

    // a non-digit closed a number with digits: stage it
    function automatic void close_number(input logic [7:0] c);
        logic [31:0] value;
        if (neg) begin
            value = -magnitude;
        end else begin
            value = (magnitude > scfp_pkg::POS_MAX) ? scfp_pkg::POS_MAX : magnitude;
        end
        if (cmd_byte == scfp_pkg::CH_E && !staged[1]) begin
            dir_staged = value;
            staged[1] = 1'b1;
            if (c == scfp_pkg::CH_COMMA) begin
                begin_number();
            end else begin
                phase = scfp_pkg::PH_SKIP;
            end
        end else begin
            magnitude = value;
            staged[0] = 1'b1;
            phase = scfp_pkg::PH_SKIP;
        end
    endfunction

    function automatic void advance_phase(input logic [7:0] c);
        case (phase)
            scfp_pkg::PH_CMD: begin
                cmd_byte = c;
                if (c == scfp_pkg::CH_X || c == scfp_pkg::CH_Y) begin
                    phase = scfp_pkg::PH_COMMA;
                end else if (c == scfp_pkg::CH_E) begin
                    begin_number();
                end else begin
                    phase = scfp_pkg::PH_SKIP;
                end
            end
            scfp_pkg::PH_COMMA: begin
                if (c == scfp_pkg::CH_COMMA) begin
                    begin_number();
                end else begin
                    phase = scfp_pkg::PH_SKIP;
                end
            end
            scfp_pkg::PH_NUM_START: begin
                if (c == scfp_pkg::CH_PLUS || c == scfp_pkg::CH_MINUS) begin
                    neg = (c == scfp_pkg::CH_MINUS);
                    phase = scfp_pkg::PH_NUM_SIGN;
                end else if (is_digit(c)) begin
                    shift_in_digit(c);
                end else if (!is_blank(c)) begin
                    phase = scfp_pkg::PH_SKIP;
                end
            end
            scfp_pkg::PH_NUM_SIGN: begin
                if (is_digit(c)) begin
                    shift_in_digit(c);
                end else begin
                    phase = scfp_pkg::PH_SKIP;
                end
            end
            scfp_pkg::PH_NUM_DIG: begin
                if (is_digit(c)) begin
                    shift_in_digit(c);
                end else begin
                    close_number(c);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic predict_frame_byte(input logic [7:0] c, output bit done,
                                      output scfp_pkg::t_result r);
        r = '0;
        done = 1'b0;
        if (phase == scfp_pkg::PH_IDLE) begin
            if (c == scfp_pkg::CH_Z) begin
                clear_frame();
                frame_len = 1;
                phase = scfp_pkg::PH_CMD;
            end
        end else begin
            frame_len++;
            if (c != scfp_pkg::CH_P) begin
                if (frame_len >= FRAME_MAX) begin
                    clear_frame();
                end else begin
                    advance_phase(c);
                end
            end else begin
                if (phase == scfp_pkg::PH_NUM_DIG) begin
                    close_number(c);
                end
                if (phase == scfp_pkg::PH_CMD) begin
                    cmd_byte = c;
                end
                r.command_known = 1'b1;
                case (cmd_byte)
                    scfp_pkg::CH_X:  r.command_code = scfp_pkg::CODE_X;
                    scfp_pkg::CH_E:  r.command_code = scfp_pkg::CODE_E;
                    scfp_pkg::CH_Y:  r.command_code = scfp_pkg::CODE_Y;
                    scfp_pkg::CH_G:  r.command_code = scfp_pkg::CODE_G;
                    scfp_pkg::CH_R:  r.command_code = scfp_pkg::CODE_R;
                    scfp_pkg::CH_S:  r.command_code = scfp_pkg::CODE_S;
                    scfp_pkg::CH_GT: r.command_code = scfp_pkg::CODE_GT;
                    scfp_pkg::CH_LT: r.command_code = scfp_pkg::CODE_LT;
                    default: begin
                        if (cmd_byte >= scfp_pkg::CH_1 && cmd_byte <= scfp_pkg::CH_9) begin
                            r.command_code = scfp_pkg::CODE_D1
                                           + 5'(cmd_byte - scfp_pkg::CH_1);
                        end else if (cmd_byte >= scfp_pkg::CH_A
                                  && cmd_byte <= scfp_pkg::CH_D) begin
                            r.command_code = scfp_pkg::CODE_A
                                           + 5'(cmd_byte - scfp_pkg::CH_A);
                        end else begin
                            r.command_code  = scfp_pkg::CODE_NONE;
                            r.command_known = 1'b0;
                        end
                    end
                endcase
                if (staged[0]) begin
                    dist_q = magnitude;
                end
                if (staged[1]) begin
                    dir_q = dir_staged;
                end
                r.distance_value    = dist_q;
                r.distance_updated  = staged[0];
                r.direction_value   = dir_q;
                r.direction_updated = staged[1];
                clear_frame();
                done = 1'b1;
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            dist_q = '0;
            dir_q  = '0;
            pending_frames.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_frames.size() == 0) begin
                    $error("result request with no frame pending, command_code %0d",
                           i_command_code);
                    fail_count++;
                end else begin
                    next_frame = pending_frames.pop_front();
                    compare_field("command_code", 32'(next_frame.command_code),
                                  32'(i_command_code));
                    compare_field("command_known", 32'(next_frame.command_known),
                                  32'(i_command_known));
                    compare_field("distance_value", next_frame.distance_value,
                                  i_distance_value);
                    compare_field("distance_updated", 32'(next_frame.distance_updated),
                                  32'(i_distance_updated));
                    compare_field("direction_value", next_frame.direction_value,
                                  i_direction_value);
                    compare_field("direction_updated", 32'(next_frame.direction_updated),
                                  32'(i_direction_updated));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_frame_byte(i_rx_byte, frame_done, next_frame);
                if (frame_done) begin
                    pending_frames.push_back(next_frame);
                end
            end
        end
        o_pending <= pending_frames.size();
    end

endmodule

>>> sim/tb_serial_command_frame_parser_core.sv
// ============================================================================
// tb_serial_command_frame_parser_core
// drives byte streams into the frame parser under random idle and stall
// patterns; a separate checker predicts and compares every frame result
// ============================================================================
module tb_serial_command_frame_parser_core;

    localparam int CYCLE_LIMIT      = 200_000;
    localparam int HOLD_CYCLES      = 150;
    localparam int BYTES_PER_PHASE  = 235;
    localparam int DRAIN_CYCLES     = 8;
    // scanf whitespace set: space, tab, lf, vt, ff, cr
    localparam logic [7:0] BLANK_CHARS [6] = '{scfp_pkg::CH_SPACE, scfp_pkg::CH_TAB,
                                               8'h0A, 8'h0B, 8'h0C, scfp_pkg::CH_CR};

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic [7:0]         i_rx_byte   = '0;
    logic               i_stall     = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [4:0]         o_command_code;
    logic               o_command_known;
    logic signed [31:0] o_distance_value;
    logic               o_distance_updated;
    logic signed [31:0] o_direction_value;
    logic               o_direction_updated;

    int fail_count;
    int pending_count;
    int cycle_count   = 0;
    // idle odds in percent for each side
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    // request for a long receiver hold-off, picked up by the sink process
    bit hold_req      = 1'b0;
    int hold_left     = 0;

    // bytes waiting to go out on the input channel
    logic [7:0] tx_q[$];

    serial_command_frame_parser_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_rx_byte           (i_rx_byte),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_command_code      (o_command_code),
        .o_command_known     (o_command_known),
        .o_distance_value    (o_distance_value),
        .o_distance_updated  (o_distance_updated),
        .o_direction_value   (o_direction_value),
        .o_direction_updated (o_direction_updated)
    );

    frame_result_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_valid),
        .i_in_stall          (o_stall),
        .i_rx_byte           (i_rx_byte),
        .i_out_valid         (o_valid),
        .i_out_stall         (i_stall),
        .i_command_code      (o_command_code),
        .i_command_known     (o_command_known),
        .i_distance_value    (o_distance_value),
        .i_distance_updated  (o_distance_updated),
        .i_direction_value   (o_direction_value),
        .i_direction_updated (o_direction_updated),
        .o_fail_count        (fail_count),
        .o_pending           (pending_count)
    );

    // 10 unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop in case the parser hangs or loses a result
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver side: random stalls, or a long counted hold-off on request
    initial begin : result_sink
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < sink_idle_pct);
            end
        end
    end

    function automatic void push_byte(input logic [7:0] b);
        tx_q.push_back(b);
    endfunction

    function automatic void push_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            tx_q.push_back(s[k]);
        end
    endfunction

    function automatic logic [7:0] rand_non_p();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == scfp_pkg::CH_P);
        return b;
    endfunction

    // random filler that never closes the frame
    function automatic void push_junk(input int count);
        repeat (count) push_byte(rand_non_p());
    endfunction

    function automatic void push_digit();
        push_byte(scfp_pkg::CH_0 + 8'($urandom_range(9)));
    endfunction

    // scanf-style integer: optional blanks, optional sign, digits (sometimes none)
    function automatic void push_number();
        int mode;
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) push_byte(BLANK_CHARS[$urandom_range(5)]);
        end
        case ($urandom_range(9))
            0, 1, 2: push_byte(scfp_pkg::CH_MINUS);
            3:       push_byte(scfp_pkg::CH_PLUS);
            default: ;
        endcase
        mode = $urandom_range(19);
        if (mode == 0) begin
            case ($urandom_range(3))
                0:       push_text("2147483647");
                1:       push_text("2147483648");
                2:       push_text("4294967295");
                default: push_text("0000000000099");
            endcase
        end else if (mode == 1) begin
            repeat ($urandom_range(11, 14)) push_digit();
        end else if (mode != 2) begin
            repeat ($urandom_range(1, 6)) push_digit();
        end
    endfunction

    // any command byte other than x, e and y that the parser knows
    function automatic logic [7:0] known_other_cmd();
        int idx;
        idx = $urandom_range(17);
        if (idx == 0) return scfp_pkg::CH_G;
        if (idx == 1) return scfp_pkg::CH_R;
        if (idx == 2) return scfp_pkg::CH_S;
        if (idx < 12) return scfp_pkg::CH_1 + 8'(idx - 3);
        if (idx == 12) return scfp_pkg::CH_GT;
        if (idx == 13) return scfp_pkg::CH_LT;
        return scfp_pkg::CH_A + 8'(idx - 14);
    endfunction

    // queue one random frame; returns the bytes that belong to a frame,
    // stray noise between frames counts as zero
    function automatic int push_random_frame();
        int kind;
        int start;
        start = tx_q.size();
        kind  = $urandom_range(99);
        if (kind < 30) begin
            // distance frames, mostly well formed
            push_byte(scfp_pkg::CH_Z);
            push_byte($urandom_range(1) ? scfp_pkg::CH_X : scfp_pkg::CH_Y);
            push_byte(($urandom_range(19) == 0) ? rand_non_p() : scfp_pkg::CH_COMMA);
            push_number();
            if ($urandom_range(9) == 0) push_junk($urandom_range(1, 4));
            push_byte(scfp_pkg::CH_P);
        end else if (kind < 55) begin
            // direction plus distance frames
            push_byte(scfp_pkg::CH_Z);
            push_byte(scfp_pkg::CH_E);
            push_number();
            push_byte(($urandom_range(9) == 0) ? rand_non_p() : scfp_pkg::CH_COMMA);
            push_number();
            push_byte(scfp_pkg::CH_P);
        end else if (kind < 75) begin
            push_byte(scfp_pkg::CH_Z);
            push_byte(known_other_cmd());
            push_junk($urandom_range(0, 4));
            push_byte(scfp_pkg::CH_P);
        end else if (kind < 82) begin
            // arbitrary command byte, may be 'p' itself
            push_byte(scfp_pkg::CH_Z);
            push_byte(8'($urandom_range(255)));
            push_junk($urandom_range(0, 3));
            push_byte(scfp_pkg::CH_P);
        end else if (kind < 88) begin
            // runs past the frame limit
            push_byte(scfp_pkg::CH_Z);
            push_junk($urandom_range(31, 40));
            push_byte(scfp_pkg::CH_P);
        end else if (kind < 96) begin
            push_byte(scfp_pkg::CH_Z);
            repeat ($urandom_range(0, 8)) push_byte(8'($urandom_range(255)));
            push_byte(scfp_pkg::CH_P);
        end else begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
            return 0;
        end
        return tx_q.size() - start;
    endfunction

    // one request on the input channel, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_tx_queue();
        while (tx_q.size() != 0) send_byte(tx_q.pop_front());
    endtask

    // drop valid and wait until every predicted result has come back
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic run_random_phase(input int src_pct, input int sink_pct);
        int frame_bytes;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        frame_bytes   = 0;
        while (frame_bytes < BYTES_PER_PHASE) begin
            frame_bytes += push_random_frame();
            send_tx_queue();
        end
    endtask

    initial begin : stimulus
        string cmd_chars;
        cmd_chars = "grs123456789><abcd";

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 34;
        sink_idle_pct = 63;

        // --- directed frames ---
        // stray bytes outside a frame, both byte extremes, a lone closer
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text("abp");
        // basic loads of each argument pattern
        push_text("zx,123p");
        push_text("zy,-45p");
        push_text("ze 12,-7p");
        // range edges and saturation both ways
        push_text("zx,2147483647p");
        push_text("zy,-2147483648p");
        push_text("zx,99999999999p");
        push_text("ze-99999999999,+4294967296p");
        // empty command and unknown commands
        push_text("zp");
        push_text("zqp");
        push_byte(scfp_pkg::CH_Z);
        push_byte(8'hFF);
        push_byte(scfp_pkg::CH_P);
        // sign with no digits, sign followed by blank
        push_text("zx,-p");
        push_text("zy,+ 5p");
        // mismatches after a complete number and before any
        push_text("ze5;6p");
        push_text("zx;5p");
        push_text("ze12,x3p");
        push_text("zx,12a34p");
        push_text("zxzp");
        // zero byte as command and inside a number
        push_text("zx,");
        push_byte(8'h00);
        push_text("5p");
        push_byte(scfp_pkg::CH_Z);
        push_byte(8'h00);
        push_byte(scfp_pkg::CH_P);
        // every whitespace character ahead of a number
        push_text("zx,");
        for (int k = 0; k < 6; k++) begin
            push_byte(BLANK_CHARS[k]);
        end
        push_text("42p");
        // longest frame that still completes
        push_text("zg");
        repeat (29) push_byte(scfp_pkg::CH_SPACE);
        push_byte(scfp_pkg::CH_P);
        // frames that hit the limit and get thrown away
        push_text("zr");
        repeat (30) push_byte(scfp_pkg::CH_1);
        push_byte(scfp_pkg::CH_P);
        push_text("zx,");
        repeat (40) push_byte(scfp_pkg::CH_1);
        push_byte(scfp_pkg::CH_P);
        // every remaining command
        for (int k = 0; k < cmd_chars.len(); k++) begin
            push_byte(scfp_pkg::CH_Z);
            push_byte(cmd_chars[k]);
            push_byte(scfp_pkg::CH_P);
        end
        send_tx_queue();

        // --- back pressure: receiver holds off while bytes keep coming ---
        src_idle_pct = 0;
        hold_req = 1'b1;
        repeat (20) begin
            push_text("zgp");
            push_text("zx,7p");
        end
        send_tx_queue();
        src_idle_pct = 34;

        // sender pause until the parser has handed out everything
        wait_results_drained();

        // --- random frames across three idle settings ---
        run_random_phase(34, 63);
        run_random_phase(63, 34);
        run_random_phase(0, 0);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
